// ===== design/cpg_pkg.sv =====
// Shared types, constants and arithmetic helpers of the curve point generator.
package cpg_pkg;

  localparam int CRD_W = 12;
  localparam int STEP_W = 6;
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [16:0] HALF_Q16 = 17'h08000;
  localparam logic [1:0] KIND_BEZIER = 2'd1;
  localparam logic [1:0] KIND_BUMP = 2'd2;

  typedef enum logic [1:0] {FR_IDLE, FR_DIV, FR_PUSH} cpg_front_e;

  // One curve request after classification, ready for point generation.
  typedef struct packed {
    logic [CRD_W-1:0] sx;
    logic [CRD_W-1:0] sy;
    logic [CRD_W-1:0] ex;
    logic [CRD_W-1:0] ey;
    logic signed [14:0] c1x;
    logic signed [14:0] c1y;
    logic signed [14:0] c2x;
    logic signed [14:0] c2y;
    logic [STEP_W-1:0] steps;
    logic [1:0] kind;
    logic [16:0] q0;
    logic [STEP_W-1:0] r0;
  } cpg_job_t;

  // sin(k*pi/32) in Q1.15, k = 0..16
  function automatic logic [15:0] sine_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0: v = 16'd0;
      5'd1: v = 16'd3212;
      5'd2: v = 16'd6393;
      5'd3: v = 16'd9512;
      5'd4: v = 16'd12540;
      5'd5: v = 16'd15447;
      5'd6: v = 16'd18205;
      5'd7: v = 16'd20788;
      5'd8: v = 16'd23170;
      5'd9: v = 16'd25330;
      5'd10: v = 16'd27246;
      5'd11: v = 16'd28899;
      5'd12: v = 16'd30274;
      5'd13: v = 16'd31357;
      5'd14: v = 16'd32138;
      5'd15: v = 16'd32610;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // Shift right by 16, rounding toward zero.
  function automatic logic signed [21:0] trunc16(input logic signed [37:0] v);
    logic [37:0] mag;
    logic [21:0] q;
    mag = v[37] ? 38'(-v) : 38'(v);
    q = mag[37:16];
    return v[37] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [13:0] sat14(input logic signed [21:0] v);
    logic signed [13:0] r;
    if (v < -22'sd8192) r = -14'sd8192;
    else if (v > 22'sd8191) r = 14'sd8191;
    else r = v[13:0];
    return r;
  endfunction

  // Divide by three, rounding toward zero, via reciprocal multiply.
  function automatic logic signed [14:0] div3(input logic signed [14:0] v);
    logic [13:0] mag;
    logic [30:0] p;
    logic [14:0] q;
    mag = v[14] ? 14'(-v) : v[13:0];
    p = 31'(mag) * 31'd43691;
    q = {1'b0, p[30:17]};
    return v[14] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [14:0] div4(input logic signed [14:0] v);
    logic [14:0] mag;
    logic [14:0] q;
    mag = v[14] ? 15'(-v) : 15'(v);
    q = {2'b00, mag[14:2]};
    return v[14] ? -$signed(q) : $signed(q);
  endfunction

endpackage

// ===== design/cpg_req_if.sv =====
// Request channel: curve endpoints, step count and curve kind.
interface cpg_req_if;
  logic valid;
  logic ready;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [11:0] end_x;
  logic [11:0] end_y;
  logic [5:0] step_count;
  logic [1:0] curve_kind;
  modport source(output valid, start_x, start_y, end_x, end_y, step_count, curve_kind,
                 input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, step_count, curve_kind,
               output ready);
endinterface

// ===== design/cpg_pt_if.sv =====
// Point channel: one curve point per transfer.
interface cpg_pt_if;
  logic valid;
  logic ready;
  logic signed [13:0] point_x;
  logic signed [13:0] point_y;
  logic [5:0] point_number;
  logic last_point;
  modport source(output valid, point_x, point_y, point_number, last_point, input ready);
  modport sink(input valid, point_x, point_y, point_number, last_point, output ready);
endinterface

// ===== design/cpg_front.sv =====
// Front end: accepts a request, clamps steps, divides out the t increment, derives controls.
module cpg_front #(
  parameter int unsigned MAX_STEPS = 63,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  cpg_req_if.sink req,
  output logic push_o,
  output cpg_pkg::cpg_job_t job_o,
  input  logic full_i
);
  import cpg_pkg::*;

  localparam logic [CRD_W-1:0] CMASK = CRD_W'((1 << COORD_BITS) - 1);
  localparam logic [STEP_W-1:0] MAX_S = STEP_W'(MAX_STEPS);

  cpg_front_e state_q, state_d;
  logic [CRD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [STEP_W-1:0] steps_q, steps_in;
  logic [1:0] kind_q;
  logic [STEP_W-1:0] rem_q;
  logic [16:0] quo_q;
  logic [4:0] cnt_q;
  logic [STEP_W:0] rem_sh;
  logic rem_ge;
  logic accept;
  logic signed [14:0] dx, dy;

  assign accept = req.valid & req.ready;

  always_comb begin
    if (req.step_count == '0) steps_in = STEP_W'(1);
    else if (req.step_count > MAX_S) steps_in = MAX_S;
    else steps_in = req.step_count;
  end

  // Dividend is 2^16: only the first bit shifted in is a one.
  assign rem_sh = {rem_q, (cnt_q == 5'd16)};
  assign rem_ge = rem_sh >= {1'b0, steps_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: if (accept) state_d = FR_DIV;
      FR_DIV:  if (cnt_q == '0) state_d = FR_PUSH;
      FR_PUSH: if (!full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    push_o = 1'b0;
    unique case (state_q)
      FR_IDLE: req.ready = 1'b1;
      FR_DIV:  ;
      FR_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= FR_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q <= req.start_x & CMASK;
      sy_q <= req.start_y & CMASK;
      ex_q <= req.end_x & CMASK;
      ey_q <= req.end_y & CMASK;
      steps_q <= steps_in;
      kind_q <= req.curve_kind;
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= 5'd16;
    end else if (state_q == FR_DIV) begin
      rem_q <= rem_ge ? STEP_W'(rem_sh - {1'b0, steps_q}) : rem_sh[STEP_W-1:0];
      quo_q <= {quo_q[15:0], rem_ge};
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign dx = 15'($signed({1'b0, ex_q})) - 15'($signed({1'b0, sx_q}));
  assign dy = 15'($signed({1'b0, ey_q})) - 15'($signed({1'b0, sy_q}));

  always_comb begin
    job_o.sx = sx_q;
    job_o.sy = sy_q;
    job_o.ex = ex_q;
    job_o.ey = ey_q;
    job_o.c1x = $signed({3'b000, sx_q}) + div3(dx);
    job_o.c1y = $signed({3'b000, sy_q}) - div4(dy);
    job_o.c2x = $signed({3'b000, sx_q}) + div3(15'(dx <<< 1));
    job_o.c2y = $signed({3'b000, ey_q}) + div4(dy);
    job_o.steps = steps_q;
    job_o.kind = kind_q;
    job_o.q0 = quo_q;
    job_o.r0 = rem_q;
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("push into full queue");
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##17 state_q == FR_PUSH) else $error("divide length wrong");

endmodule

// ===== design/cpg_queue.sv =====
// Two-entry job queue between front end and point engine.
module cpg_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cpg_pkg::cpg_job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output cpg_pkg::cpg_job_t job_o,
  output logic empty_o
);
  import cpg_pkg::*;

  cpg_job_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

// ===== design/cpg_back.sv =====
// Point engine: steps t through a job and computes each point in a five-stage pipeline.
module cpg_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  cpg_pkg::cpg_job_t job_i,
  input  logic empty_i,
  output logic pop_o,
  input  logic [7:0] amp_i,
  cpg_pt_if.source pt
);
  import cpg_pkg::*;

  cpg_job_t cur_q;
  logic active_q;
  logic [5:0] i_q;
  logic [16:0] t_q;
  logic [5:0] r_q;
  logic [6:0] r_sum;
  logic carry, last0, issue, adv, pipe_busy;
  logic [16:0] h;

  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic [5:0] i1_q, i2_q, i3_q, i4_q;
  logic l1_q, l2_q, l3_q, l4_q;
  logic [16:0] t1_q, u1_q, t2_q, u2_q, uu2_q, tt2_q;
  logic [15:0] base1_q, s2_q;
  logic [11:0] dlt1_q;
  logic [10:0] frac1_q;
  logic sat1_q;
  logic signed [30:0] lx2_q, ly2_q, ly3_q;
  logic [18:0] w0_q, w1_q, w2_q, w3_q;
  logic signed [21:0] lx3_q, ly3s_q, lx4_q, ly4_q;
  logic [23:0] bump3_q;
  logic signed [34:0] px_q [4];
  logic signed [34:0] py_q [4];
  logic signed [32:0] by4_q;
  logic signed [12:0] dx, dy;
  logic signed [14:0] pxs [4];
  logic signed [14:0] pys [4];
  logic [22:0] dfr;
  logic [33:0] m_uu, m_tt, m_w0, m_w1, m_w2, m_w3;
  logic signed [37:0] sumx, sumy;
  logic signed [21:0] bx, by, rx, ry;

  assign pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign adv = !(ov_q & !pt.ready);
  assign pop_o = !active_q & !empty_i & !pipe_busy;
  assign issue = active_q & adv;
  assign last0 = i_q == cur_q.steps;
  assign r_sum = {1'b0, r_q} + {1'b0, cur_q.r0};
  assign carry = r_sum >= {1'b0, cur_q.steps};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= 1'b0;
    else if (pop_o) active_q <= 1'b1;
    else if (issue && last0) active_q <= 1'b0;
  end

  // t = floor(i * 2^16 / steps) advanced by quotient plus remainder carry
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
      i_q <= '0;
      t_q <= '0;
      r_q <= '0;
    end else if (issue) begin
      i_q <= i_q + 6'd1;
      t_q <= t_q + cur_q.q0 + 17'(carry);
      r_q <= carry ? 6'(r_sum - {1'b0, cur_q.steps}) : r_sum[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= active_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      ov_q <= v4_q;
    end
  end

  assign h = (t_q <= HALF_Q16) ? t_q : ONE_Q16 - t_q;
  assign dx = 13'($signed({1'b0, cur_q.ex})) - 13'($signed({1'b0, cur_q.sx}));
  assign dy = 13'($signed({1'b0, cur_q.ey})) - 13'($signed({1'b0, cur_q.sy}));
  assign dfr = 23'(dlt1_q) * 23'(frac1_q);
  assign m_uu = 34'(u1_q) * 34'(u1_q);
  assign m_tt = 34'(t1_q) * 34'(t1_q);
  assign m_w0 = 34'(uu2_q) * 34'(u2_q);
  assign m_w1 = 34'(uu2_q) * 34'(t2_q);
  assign m_w2 = 34'(u2_q) * 34'(tt2_q);
  assign m_w3 = 34'(tt2_q) * 34'(t2_q);

  always_comb begin
    pxs[0] = $signed({3'b000, cur_q.sx});
    pxs[1] = cur_q.c1x;
    pxs[2] = cur_q.c2x;
    pxs[3] = $signed({3'b000, cur_q.ex});
    pys[0] = $signed({3'b000, cur_q.sy});
    pys[1] = cur_q.c1y;
    pys[2] = cur_q.c2y;
    pys[3] = $signed({3'b000, cur_q.ey});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: t, 1-t, sine table lookup
      i1_q <= i_q;
      l1_q <= last0;
      t1_q <= t_q;
      u1_q <= ONE_Q16 - t_q;
      base1_q <= sine_tab({1'b0, h[14:11]});
      dlt1_q <= 12'(sine_tab(5'(h[14:11]) + 5'd1) - sine_tab({1'b0, h[14:11]}));
      frac1_q <= h[10:0];
      sat1_q <= h[15];
      // stage 2: squares, linear products, sine interpolation
      i2_q <= i1_q;
      l2_q <= l1_q;
      t2_q <= t1_q;
      u2_q <= u1_q;
      uu2_q <= m_uu[32:16];
      tt2_q <= m_tt[32:16];
      lx2_q <= $signed({1'b0, t1_q}) * 31'(dx);
      ly2_q <= $signed({1'b0, t1_q}) * 31'(dy);
      s2_q <= sat1_q ? 16'd32768 : base1_q + 16'(dfr[22:11]);
      // stage 3: Bernstein weights, linear points, bump product
      i3_q <= i2_q;
      l3_q <= l2_q;
      w0_q <= 19'(m_w0[33:16]);
      w1_q <= 19'(m_w1[33:16]) * 19'd3;
      w2_q <= 19'(m_w2[33:16]) * 19'd3;
      w3_q <= 19'(m_w3[33:16]);
      lx3_q <= $signed({10'd0, cur_q.sx}) + trunc16(38'(lx2_q));
      ly3s_q <= $signed({10'd0, cur_q.sy}) + trunc16(38'(ly2_q));
      ly3_q <= ly2_q;
      bump3_q <= 24'(s2_q) * 24'(amp_i);
      // stage 4: weighted control points, bump sum
      i4_q <= i3_q;
      l4_q <= l3_q;
      px_q[0] <= $signed({1'b0, w0_q}) * 35'(pxs[0]);
      px_q[1] <= $signed({1'b0, w1_q}) * 35'(pxs[1]);
      px_q[2] <= $signed({1'b0, w2_q}) * 35'(pxs[2]);
      px_q[3] <= $signed({1'b0, w3_q}) * 35'(pxs[3]);
      py_q[0] <= $signed({1'b0, w0_q}) * 35'(pys[0]);
      py_q[1] <= $signed({1'b0, w1_q}) * 35'(pys[1]);
      py_q[2] <= $signed({1'b0, w2_q}) * 35'(pys[2]);
      py_q[3] <= $signed({1'b0, w3_q}) * 35'(pys[3]);
      by4_q <= $signed({8'd0, bump3_q, 1'b0}) + 33'(ly3_q);
      lx4_q <= lx3_q;
      ly4_q <= ly3s_q;
      // stage 5: select kind, saturate into the output register
      pt.point_x <= sat14(rx);
      pt.point_y <= sat14(ry);
      pt.point_number <= i4_q;
      pt.last_point <= l4_q;
    end
  end

  always_comb begin
    sumx = 38'(px_q[0]) + 38'(px_q[1]) + 38'(px_q[2]) + 38'(px_q[3]);
    sumy = 38'(py_q[0]) + 38'(py_q[1]) + 38'(py_q[2]) + 38'(py_q[3]);
    bx = trunc16(sumx);
    by = $signed({10'd0, cur_q.sy}) + trunc16(38'(by4_q));
    case (cur_q.kind)
      KIND_BEZIER: begin
        rx = bx;
        ry = trunc16(sumy);
      end
      KIND_BUMP: begin
        rx = lx4_q;
        ry = by;
      end
      default: begin
        rx = lx4_q;
        ry = ly4_q;
      end
    endcase
  end

  assign pt.valid = ov_q;

  a_pop_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !(v1_q | v2_q | v3_q | v4_q)) else $error("job switched with pipe busy");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> r_q < cur_q.steps) else $error("t remainder out of range");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && last0 |=> !active_q) else $error("run continues past last point");

endmodule

// ===== design/curve_point_generator_unit.sv =====
// Top level of the curve point generator.
// Usage:
//   req_i carries one curve request (start, end, step count, curve kind) per transfer.
//   pt_o returns step_count+1 points (a step count of 0 gives two points), point_number
//   counting up from 0 and last_point set on the final one.
//   cfg_we_i/cfg_wdata_i write bump_amplitude; write it only while no run is in flight.
// Timing:
//   The front end takes one request at a time (accept, restoring divide for the t increment,
//   hand-off into a two-entry queue, held while the queue is full) and may accept the next
//   request while the point engine still works.
//   The point engine starts a job only once stages 1 to 4 of its five-stage pipeline have
//   drained, then issues one point per cycle while pt_o does not stall; each point passes
//   through stages 1 to 4 into the output register (stage 5), and the next job can leave
//   the queue only after the last point of the run has left stage 4.
// Reset:
//   rst_ni clears all control state and sets bump_amplitude to 30.
// Backpressure:
//   While pt_o holds a point that is not taken, the whole pipeline holds; the queue
//   and front end keep taking requests until the queue fills.
module curve_point_generator_unit #(
  parameter int unsigned MAX_STEPS = 63,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  cpg_req_if.sink req_i,
  cpg_pt_if.source pt_o
);
  import cpg_pkg::*;

  logic [7:0] amp_q;
  logic push, full, pop, empty;
  cpg_job_t job_in, job_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) amp_q <= 8'd30;
    else if (cfg_we_i) amp_q <= cfg_wdata_i;
  end

  cpg_front #(.MAX_STEPS(MAX_STEPS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni, .req(req_i), .push_o(push), .job_o(job_in), .full_i(full)
  );

  cpg_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .full_o(full),
    .pop_i(pop), .job_o(job_out), .empty_o(empty)
  );

  cpg_back u_back (
    .clk_i, .rst_ni, .job_i(job_out), .empty_i(empty), .pop_o(pop),
    .amp_i(amp_q), .pt(pt_o)
  );

endmodule
